FILE: rtl/ile_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants for the indexed list engine: request and
// response transactions, mode and status codes, and per-cell shift control.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned LEN_W        = 7;

  // Request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_READ   = 3'd0,
    MODE_FRONT  = 3'd1,
    MODE_BACK   = 3'd2,
    MODE_AT     = 3'd3,
    MODE_DELETE = 3'd4
  } mode_t;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Value returned by anything other than a successful read
  localparam logic signed [DATA_W-1:0] MISS_WORD = '1;

  // Shift operation broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

  // Request transaction
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_value;
  } ile_in_t;

  // Response transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic [LEN_W-1:0]         length;
  } ile_out_t;

endpackage

FILE: rtl/indexed_list_engine_unit.sv
`timescale 1ns / 1ps
// Indexed list engine: ordered list of up to CAPACITY signed 32-bit values.
// The response is registered: it appears in the cycle after acceptance.
// Throughput: one request per cycle when no response is stalled; the cell row
// shifts all slots in the same cycle as the request, and the response register
// decouples the sides. Reset: rst_n (synchronous, active low) empties the list and the output.
// ----------------------------------------------------------------------------
// indexed_list_engine_unit
// Decodes requests, drives the row of list cells and registers one response
// transaction per request.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit #(
  parameter int unsigned CAPACITY = ile_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ile_pkg::ile_in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ile_pkg::ile_out_t out_data
);
  import ile_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       cnt_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  ile_out_t            out_data_r;
  ile_out_t            resp;
  logic                accept;
  logic [PW-1:0]       pos_ext;
  logic [PW-1:0]       cnt_ext;
  logic                full;
  cell_ctrl_t          ctrl;
  logic [IW-1:0]       shift_pos;
  logic [IW-1:0]       rd_pos;
  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic signed [DATA_W-1:0] cell_rd  [CAPACITY];
  logic signed [DATA_W-1:0] rd_word;

  assign accept   = in_valid & ~in_stall;
  assign in_stall = out_valid_r & out_stall;
  assign pos_ext  = PW'(in_data.position);
  assign cnt_ext  = PW'(cnt_r);
  assign full     = (cnt_r == CW'(CAPACITY));
  assign rd_pos   = IW'(in_data.position);

  // Combine the gated per-cell read values
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // Decode the request into a shift, a count update and a response
  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.value  = in_data.data_value;
    shift_pos   = '0;
    cnt_nxt     = cnt_r;
    resp.read_value = MISS_WORD;
    resp.status     = ST_DONE;
    unique case (in_data.mode)
      MODE_READ: begin
        if (pos_ext < cnt_ext) begin
          resp.read_value = rd_word;
        end else begin
          resp.status = ST_RANGE;
        end
      end
      MODE_FRONT, MODE_BACK: begin
        if (full) begin
          resp.status = ST_FULL;
        end else begin
          ctrl.op   = CELL_INS;
          shift_pos = (in_data.mode == MODE_FRONT) ? '0 : IW'(cnt_r);
          cnt_nxt   = cnt_r + CW'(1);
        end
      end
      MODE_AT: begin
        if (pos_ext > cnt_ext) begin
          resp.status = ST_RANGE;
        end else if (full) begin
          resp.status = ST_FULL;
        end else begin
          ctrl.op   = CELL_INS;
          shift_pos = IW'(pos_ext);
          cnt_nxt   = cnt_r + CW'(1);
        end
      end
      MODE_DELETE: begin
        if (pos_ext < cnt_ext) begin
          ctrl.op   = CELL_DEL;
          shift_pos = IW'(pos_ext);
          cnt_nxt   = cnt_r - CW'(1);
        end else begin
          resp.status = ST_RANGE;
        end
      end
      default: begin
        ctrl.op = CELL_HOLD;
      end
    endcase
    resp.length = LEN_W'(cnt_nxt);
    // Drop the shift unless the transaction is taken this cycle
    if (!accept) begin
      ctrl.op = CELL_HOLD;
    end
  end

  // Row of list cells, each fed by its neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ile_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .shift_pos (shift_pos),
      .rd_pos    (rd_pos),
      .left_val  ((g == 0) ? in_data.data_value : cell_val[(g == 0) ? 0 : g - 1]),
      .right_val ((g == CAPACITY - 1) ? cell_val[g]
                                      : cell_val[(g == CAPACITY - 1) ? g : g + 1]),
      .val       (cell_val[g]),
      .rd_val    (cell_rd[g])
    );
  end

  // Hold the response until it is taken; advance on a new transaction
  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= resp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/ile_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_cell
// One list slot. Holds one value and, on an insert or delete, takes the new
// value or that of its left or right neighbor so all slots shift together.
// ----------------------------------------------------------------------------
module ile_cell #(
  parameter int unsigned IW  = 6,
  parameter int unsigned IDX = 0
) (
  input  logic                            clk,
  input  ile_pkg::cell_ctrl_t             ctrl,
  input  logic [IW-1:0]                   shift_pos,
  input  logic [IW-1:0]                   rd_pos,
  input  logic signed [ile_pkg::DATA_W-1:0] left_val,
  input  logic signed [ile_pkg::DATA_W-1:0] right_val,
  output logic signed [ile_pkg::DATA_W-1:0] val,
  output logic signed [ile_pkg::DATA_W-1:0] rd_val
);
  import ile_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;

  // Pick the next slot content from the shift direction
  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      CELL_INS: begin
        if (MY_IDX == shift_pos) begin
          entry_nxt = ctrl.value;
        end else if (MY_IDX > shift_pos) begin
          entry_nxt = left_val;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= shift_pos) begin
          entry_nxt = right_val;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  // Slot storage, no reset: a slot is read only after it was written
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign val    = entry_r;
  assign rd_val = (MY_IDX == rd_pos) ? entry_r : '0;

endmodule

FILE: rtl/ile_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_checker
// Port-level checks for the indexed list engine, attached by bind.
// ----------------------------------------------------------------------------
module ile_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input ile_pkg::ile_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input ile_pkg::ile_out_t out_data
);
  import ile_pkg::*;

  // A stalled request holds until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled request changed");

  // Every accepted request yields a response in the next cycle
  a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no response");

  // A stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled response changed");

  // Status stays within its defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_DONE || out_data.status == ST_RANGE ||
                   out_data.status == ST_FULL))
    else $error("undefined status code");

  // A failed request never returns data
  a_fail_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_DONE) |-> (out_data.read_value == MISS_WORD))
    else $error("failed request returned data");

endmodule

bind indexed_list_engine_unit ile_checker u_ile_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
